// ===== rtl/tldt_pkg.sv =====
// Package for the touch list drag and tap classifier.
// Holds field widths, event and register codes, reset values and the divider
// request and response types. No dependencies.
`default_nettype none

package tldt_pkg;

    localparam int COORD_W    = 9;
    localparam int SCROLL_W   = 10;
    localparam int TICK_W     = 32;
    localparam int EVENT_W    = 2;
    localparam int TOP_W      = 9;
    localparam int VIS_W      = 6;
    localparam int ROWH_W     = 8;
    localparam int COUNT_W    = 10;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COORD_W-1:0] DRAG_THRESHOLD = 9'd8;

    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESSED  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_SCROLLED = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TAPPED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LIST_TOP_Y      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_HEIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REDRAW_INTERVAL = 3'd4;

    localparam logic [TOP_W-1:0]      RST_LIST_TOP_Y      = 9'd30;
    localparam logic [VIS_W-1:0]      RST_VISIBLE_ROWS    = 6'd5;
    localparam logic [ROWH_W-1:0]     RST_ROW_HEIGHT      = 8'd40;
    localparam logic [COUNT_W-1:0]    RST_ITEM_COUNT      = 10'd0;
    localparam logic [INTERVAL_W-1:0] RST_REDRAW_INTERVAL = 16'd50;

    typedef struct packed {
        logic                start;
        logic [COORD_W-1:0]  dividend;
        logic [ROWH_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [COORD_W-1:0]  quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/tldt_in_if.sv =====
// Input channel of the touch list classifier: handshake and touch sample fields.
// Depends on tldt_pkg for field widths.
`default_nettype none

interface tldt_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic                              pressed;
    logic                              point_valid;
    logic [tldt_pkg::COORD_W-1:0]      touch_x;
    logic [tldt_pkg::COORD_W-1:0]      touch_y;
    logic [tldt_pkg::SCROLL_W-1:0]     scroll_in;
    logic [tldt_pkg::TICK_W-1:0]       now_ticks;

    modport source (output valid, kind, pressed, point_valid, touch_x, touch_y,
                    scroll_in, now_ticks, input ready);
    modport sink   (input valid, kind, pressed, point_valid, touch_x, touch_y,
                    scroll_in, now_ticks, output ready);
endinterface

`default_nettype wire

// ===== rtl/tldt_out_if.sv =====
// Result channel of the touch list classifier: handshake and result fields.
// Depends on tldt_pkg for field widths.
`default_nettype none

interface tldt_out_if;
    logic                              valid;
    logic                              ready;
    logic [tldt_pkg::EVENT_W-1:0]      event_res;
    logic [tldt_pkg::SCROLL_W-1:0]     scroll_out;
    logic [tldt_pkg::COORD_W-1:0]      tap_x;
    logic [tldt_pkg::COORD_W-1:0]      tap_y;

    modport source (output valid, event_res, scroll_out, tap_x, tap_y, input ready);
    modport sink   (input valid, event_res, scroll_out, tap_x, tap_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/tldt_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tldt_pkg for widths and the request and response structs.
`default_nettype none

module tldt_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tldt_pkg::t_div_req    i_req,
    output tldt_pkg::t_div_rsp    o_rsp
);
    localparam int QW    = tldt_pkg::COORD_W;
    localparam int DW    = tldt_pkg::ROWH_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_div;

    logic [DW:0]      w_shift;
    logic             w_fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign w_shift = {r_rem, r_quo[QW-1]};
    assign w_fits  = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? DW'(w_shift - {1'b0, r_div}) : w_shift[DW-1:0];
            r_quo <= {r_quo[QW-2:0], w_fits};
        end
    end

    assign o_rsp.done     = !r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/touch_list_drag_tap_classifier.sv =====
// Top level of the touch list drag and tap classifier: sequencer, gesture
// state, configuration registers and result register.
// Depends on tldt_pkg, tldt_in_if, tldt_out_if and tldt_div.
`default_nettype none

// Channel  Direction  Handshake          Contents
// i_in     in         valid/ready        kind, pressed, point_valid, x, y, scroll, ticks
// o_out    out        valid/ready        event_res, scroll_out, tap_x, tap_y
// i_cfg_*  in         write enable only  register index and write data
//
// A held sample with a point while tracking first waits in ST_DIV while the
// bit-serial divider works out the row count, then is classified in ST_FIN.
// Every other transaction goes straight to ST_FIN. Input is ready again once
// ST_FIN has loaded the result register. The result register lets the next
// transaction be accepted while a result still waits on o_out. Reset is
// synchronous and active low; it loads the register defaults and clears all
// gesture state. A stalled output holds the finished item in the classify
// step until o_out frees up.

module touch_list_drag_tap_classifier (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    tldt_in_if.sink                             i_in,
    tldt_out_if.source                          o_out,
    input  wire                                 i_cfg_we,
    input  wire [tldt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [tldt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int CW = tldt_pkg::COORD_W;
    localparam int SW = tldt_pkg::SCROLL_W;
    localparam int TW = tldt_pkg::TICK_W;
    localparam int EW = tldt_pkg::EVENT_W;
    // Signed width that holds start scroll plus or minus a full row count.
    localparam int NSW = SW + 2;
    // Band end: list top plus visible rows times row height.
    localparam int BW = tldt_pkg::VIS_W + tldt_pkg::ROWH_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Configuration registers.
    logic [tldt_pkg::TOP_W-1:0]      r_list_top_y;
    logic [tldt_pkg::VIS_W-1:0]      r_visible_rows;
    logic [tldt_pkg::ROWH_W-1:0]     r_row_height;
    logic [tldt_pkg::COUNT_W-1:0]    r_item_count;
    logic [tldt_pkg::INTERVAL_W-1:0] r_redraw_interval;

    // Sequencer and latched transaction.
    logic [1:0]   r_state;
    logic         r_kind;
    logic         r_pressed;
    logic         r_valid;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [SW-1:0] r_scroll;
    logic [TW-1:0] r_now;

    // Gesture state.
    logic          r_was_down, n_was_down;
    logic          r_tracking, n_tracking;
    logic          r_moved, n_moved;
    logic          r_owed, n_owed;
    logic [CW-1:0] r_start_y, n_start_y;
    logic [SW-1:0] r_start_scroll, n_start_scroll;
    logic [TW-1:0] r_last_redraw, n_last_redraw;
    logic [CW-1:0] r_press_x, n_press_x;
    logic [CW-1:0] r_press_y, n_press_y;

    // Result register.
    logic          r_out_valid;
    logic [EW-1:0] r_event, n_event;
    logic [SW-1:0] r_scroll_out, n_scroll_out;

    tldt_pkg::t_div_req w_div_req;
    tldt_pkg::t_div_rsp w_div_rsp;

    logic          w_accept;
    logic          w_need_div;
    logic          w_load;
    logic [CW-1:0] w_in_mag;
    logic          w_neg;
    logic [CW-1:0] w_mag;
    logic [BW-1:0] w_band_end;
    logic          w_in_band;
    logic signed [NSW-1:0] w_ns_raw;
    logic [SW-1:0] w_top;
    logic [SW-1:0] w_ns;
    logic [TW-1:0] w_elapsed;
    logic          w_due;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Only a held sample with a point while tracking needs the row count.
    assign w_need_div = !i_in.kind && i_in.pressed && i_in.point_valid
                        && r_was_down && r_tracking;

    // Distance from the press start, taken from the incoming sample so the
    // divider can start in the accept cycle.
    assign w_in_mag = (i_in.touch_y < r_start_y) ? (r_start_y - i_in.touch_y)
                                                 : (i_in.touch_y - r_start_y);

    assign w_div_req.start    = w_accept && w_need_div;
    assign w_div_req.dividend = w_in_mag;
    assign w_div_req.divisor  = (r_row_height == '0) ? tldt_pkg::ROWH_W'(1) : r_row_height;

    tldt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // The finished item leaves the classify step once the result register is free.
    assign w_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_need_div ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_in.kind;
            r_pressed <= i_in.pressed;
            r_valid   <= i_in.point_valid;
            r_x       <= i_in.touch_x;
            r_y       <= i_in.touch_y;
            r_scroll  <= i_in.scroll_in;
            r_now     <= i_in.now_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_top_y      <= tldt_pkg::RST_LIST_TOP_Y;
            r_visible_rows    <= tldt_pkg::RST_VISIBLE_ROWS;
            r_row_height      <= tldt_pkg::RST_ROW_HEIGHT;
            r_item_count      <= tldt_pkg::RST_ITEM_COUNT;
            r_redraw_interval <= tldt_pkg::RST_REDRAW_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tldt_pkg::REG_LIST_TOP_Y:
                    r_list_top_y <= i_cfg_data[tldt_pkg::TOP_W-1:0];
                tldt_pkg::REG_VISIBLE_ROWS:
                    r_visible_rows <= i_cfg_data[tldt_pkg::VIS_W-1:0];
                tldt_pkg::REG_ROW_HEIGHT:
                    r_row_height <= i_cfg_data[tldt_pkg::ROWH_W-1:0];
                tldt_pkg::REG_ITEM_COUNT:
                    r_item_count <= i_cfg_data[tldt_pkg::COUNT_W-1:0];
                tldt_pkg::REG_REDRAW_INTERVAL:
                    r_redraw_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Press band: a zero row height or zero visible rows leaves it empty.
    assign w_band_end = BW'(r_list_top_y) + BW'(r_visible_rows * r_row_height);
    assign w_in_band  = (r_y >= r_list_top_y) && (BW'(r_y) < w_band_end);

    // Signed vertical offset from the press start, as sign and magnitude.
    assign w_neg = r_y < r_start_y;
    assign w_mag = w_neg ? (r_start_y - r_y) : (r_y - r_start_y);

    // Moving down scrolls back; the row count truncates toward zero.
    assign w_ns_raw = w_neg
        ? $signed(NSW'(r_start_scroll) + NSW'(w_div_rsp.quotient))
        : $signed(NSW'(r_start_scroll) - NSW'(w_div_rsp.quotient));

    // Last scroll position that still fills the view, or zero for short lists.
    assign w_top = (r_item_count > tldt_pkg::COUNT_W'(r_visible_rows))
                   ? SW'(r_item_count - tldt_pkg::COUNT_W'(r_visible_rows)) : '0;

    always_comb begin
        if (w_ns_raw < 0) begin
            w_ns = '0;
        end else if (w_ns_raw > $signed(NSW'(w_top))) begin
            w_ns = w_top;
        end else begin
            w_ns = w_ns_raw[SW-1:0];
        end
    end

    // A redraw stamp of zero counts as never redrawn.
    assign w_elapsed = r_now - r_last_redraw;
    assign w_due = (r_last_redraw == '0) || (w_elapsed >= TW'(r_redraw_interval));

    always_comb begin
        n_was_down     = r_was_down;
        n_tracking     = r_tracking;
        n_moved        = r_moved;
        n_owed         = r_owed;
        n_start_y      = r_start_y;
        n_start_scroll = r_start_scroll;
        n_last_redraw  = r_last_redraw;
        n_press_x      = r_press_x;
        n_press_y      = r_press_y;
        n_event        = tldt_pkg::EV_NONE;
        n_scroll_out   = r_scroll;

        if (r_kind) begin
            n_was_down    = 1'b0;
            n_tracking    = 1'b0;
            n_moved       = 1'b0;
            n_owed        = 1'b0;
            n_last_redraw = '0;
        end else if (r_pressed && !r_was_down) begin
            n_was_down     = 1'b1;
            n_tracking     = r_valid && w_in_band;
            n_moved        = 1'b0;
            n_owed         = 1'b0;
            n_start_y      = r_valid ? r_y : '0;
            n_start_scroll = r_scroll;
            if (r_valid) begin
                n_press_x = r_x;
                n_press_y = r_y;
            end
            n_event = tldt_pkg::EV_PRESSED;
        end else if (r_pressed) begin
            n_event = tldt_pkg::EV_PRESSED;
            if (r_valid && r_tracking) begin
                if (w_mag > tldt_pkg::DRAG_THRESHOLD) begin
                    n_moved = 1'b1;
                end
                if (w_ns != r_scroll) begin
                    n_scroll_out = w_ns;
                    n_owed       = 1'b1;
                    if (w_due) begin
                        n_last_redraw = r_now;
                        n_owed        = 1'b0;
                        n_event       = tldt_pkg::EV_SCROLLED;
                    end
                end
            end
        end else if (r_was_down) begin
            n_was_down = 1'b0;
            n_tracking = 1'b0;
            if (r_moved) begin
                n_owed  = 1'b0;
                n_event = r_owed ? tldt_pkg::EV_SCROLLED : tldt_pkg::EV_NONE;
            end else begin
                n_event = tldt_pkg::EV_TAPPED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down     <= 1'b0;
            r_tracking     <= 1'b0;
            r_moved        <= 1'b0;
            r_owed         <= 1'b0;
            r_start_y      <= '0;
            r_start_scroll <= '0;
            r_last_redraw  <= '0;
            r_press_x      <= '0;
            r_press_y      <= '0;
        end else if (w_load) begin
            r_was_down     <= n_was_down;
            r_tracking     <= n_tracking;
            r_moved        <= n_moved;
            r_owed         <= n_owed;
            r_start_y      <= n_start_y;
            r_start_scroll <= n_start_scroll;
            r_last_redraw  <= n_last_redraw;
            r_press_x      <= n_press_x;
            r_press_y      <= n_press_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The tap point comes from the updated press state, so it rides along.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_event      <= n_event;
            r_scroll_out <= n_scroll_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_event;
    assign o_out.scroll_out = r_scroll_out;
    assign o_out.tap_x      = r_press_x;
    assign o_out.tap_y      = r_press_y;

endmodule

`default_nettype wire

// ===== rtl/tldt_chk.sv =====
// Port-level checker for the touch list classifier, bound to its top level.
// Depends on tldt_pkg for field widths.
`default_nettype none

module tldt_chk (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_in_valid,
    input wire                                i_in_ready,
    input wire                                i_out_valid,
    input wire                                i_out_ready,
    input wire [tldt_pkg::EVENT_W-1:0]        i_event,
    input wire [tldt_pkg::SCROLL_W-1:0]       i_scroll_out
);

    // One transaction at a time: the input closes right after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");

    // Reset leaves no stale result on the output.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_event) && $stable(i_scroll_out))
        else $error("result changed while stalled");

endmodule

bind touch_list_drag_tap_classifier tldt_chk u_tldt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_event     (o_out.event_res),
    .i_scroll_out(o_out.scroll_out)
);

`default_nettype wire
